// ===== rtl/core/kwnb_pkg.sv =====
package kwnb_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_WORD   = 2'd2
	} lex_mode_t;

	localparam int KW_COUNT  = 24;
	localparam int KW_MAXLEN = 9;
	localparam int RQ_DEPTH  = 4;

	localparam logic [4:0] TOK_LBRACE  = 5'd0;
	localparam logic [4:0] TOK_RBRACE  = 5'd1;
	localparam logic [4:0] TOK_NUMBER  = 5'd2;
	localparam logic [4:0] TOK_KW_BASE = 5'd3;

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [4:0]  token_code;
		logic [30:0] number_value;
		logic        lex_error;
		logic        last_of_run;
	} lex_res_t;

	typedef struct packed {
		logic     v0;
		logic     v1;
		lex_res_t r0;
		lex_res_t r1;
	} lex_push_t;

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd8, 4'd9, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd8, 4'd5,
		4'd6, 4'd4, 4'd4, 4'd5, 4'd8, 4'd4, 4'd7, 4'd8, 4'd5, 4'd4, 4'd4, 4'd8
	};

	// text is right-justified: first letter in the highest used byte
	localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"list", "topology", "resources", "access", "local", "remote",
		"accept", "return", "systems", "system", "hardware", "grant",
		"revoke", "quit", "help", "state", "children", "core",
		"logical", "physical", "cache", "proc", "numa", "hostname"
	};

endpackage

// ===== rtl/core/kwnb_lex.sv =====
module kwnb_lex #(
	parameter int MAX_KEYWORD_LEN = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          byte_in,
	input  logic                end_of_data,
	input  logic                room,
	output kwnb_pkg::lex_push_t push
);
	import kwnb_pkg::*;

	localparam int LW = $clog2(MAX_KEYWORD_LEN + 1);
	localparam int IW = $clog2(MAX_KEYWORD_LEN);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eod_s1;
	logic        advance;

	lex_mode_t   mode_q, mode_d;
	logic [30:0] acc_q, acc_d;
	logic [7:0]  chars_q [MAX_KEYWORD_LEN];
	logic [LW-1:0] len_q, len_d;
	logic        overlong_q, overlong_d;
	logic        ch_we;
	logic [IW-1:0] ch_idx;
	logic        idle_go;

	logic        is_letter, is_digit, is_space, is_lbr, is_rbr;
	logic [30:0] digit_val;
	logic [34:0] acc_prod;
	logic [30:0] acc_sat;
	logic        kw_hit;
	logic [4:0]  kw_code;
	logic        pre_v, id_v;
	lex_res_t    pre_r, id_r;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			eod_s1  <= end_of_data;
		end
	end

	assign is_letter = (byte_s1 >= 8'h61 && byte_s1 <= 8'h7A) ||
	                   (byte_s1 >= 8'h41 && byte_s1 <= 8'h5A);
	assign is_digit  = byte_s1 >= 8'h30 && byte_s1 <= 8'h39;
	assign is_space  = byte_s1 == 8'h20 || (byte_s1 >= 8'h09 && byte_s1 <= 8'h0D);
	assign is_lbr    = byte_s1 == CH_LBRACE;
	assign is_rbr    = byte_s1 == CH_RBRACE;

	assign digit_val = {27'b0, byte_s1[3:0]};
	assign acc_prod  = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {31'b0, byte_s1[3:0]};
	assign acc_sat   = (acc_prod > {4'b0, NUM_MAX}) ? NUM_MAX : acc_prod[30:0];

	always_comb begin
		logic eq;
		int   base;
		kw_hit  = 1'b0;
		kw_code = TOK_LBRACE;
		for (int i = 0; i < KW_COUNT; i++) begin
			eq = (len_q == LW'(KW_LEN[i]));
			for (int j = 0; j < KW_MAXLEN; j++) begin
				if (j < int'(KW_LEN[i])) begin
					base = (int'(KW_LEN[i]) - 1 - j) * 8;
					if (chars_q[j] != KW_TEXT[i][base +: 8]) begin
						eq = 1'b0;
					end
				end
			end
			if (eq && !kw_hit) begin
				kw_hit  = 1'b1;
				kw_code = TOK_KW_BASE + 5'(i);
			end
		end
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		acc_d      = acc_q;
		len_d      = len_q;
		overlong_d = overlong_q;
		ch_we      = 1'b0;
		ch_idx     = '0;
		idle_go    = 1'b0;
		unique case (mode_q)
			MODE_NUMBER: begin
				if (is_digit) begin
					acc_d = acc_sat;
				end else if (is_letter) begin
					mode_d = MODE_IDLE;
				end else begin
					idle_go = 1'b1;
				end
			end
			MODE_WORD: begin
				if (is_letter) begin
					if (eod_s1) begin
						mode_d = MODE_IDLE;
					end else if (len_q < LW'(MAX_KEYWORD_LEN)) begin
						ch_we  = 1'b1;
						ch_idx = len_q[IW-1:0];
						len_d  = len_q + LW'(1);
					end else begin
						overlong_d = 1'b1;
					end
				end else begin
					idle_go = 1'b1;
				end
			end
			default: begin
				idle_go = 1'b1;
			end
		endcase
		if (idle_go) begin
			mode_d = MODE_IDLE;
			if (is_digit) begin
				acc_d  = digit_val;
				mode_d = MODE_NUMBER;
			end else if (is_letter) begin
				ch_we      = 1'b1;
				ch_idx     = '0;
				len_d      = LW'(1);
				overlong_d = 1'b0;
				mode_d     = MODE_WORD;
			end
		end
		if (eod_s1) begin
			mode_d = MODE_IDLE;
		end
	end

	// results
	always_comb begin
		pre_v = 1'b0;
		pre_r = '0;
		id_v  = 1'b0;
		id_r  = '0;
		unique case (mode_q)
			MODE_NUMBER: begin
				if (is_digit) begin
					if (eod_s1) begin
						pre_v              = 1'b1;
						pre_r.token_code   = TOK_NUMBER;
						pre_r.number_value = acc_sat;
					end
				end else if (is_letter) begin
					pre_v           = 1'b1;
					pre_r.lex_error = 1'b1;
				end else begin
					pre_v              = 1'b1;
					pre_r.token_code   = TOK_NUMBER;
					pre_r.number_value = acc_q;
				end
			end
			MODE_WORD: begin
				if (is_letter) begin
					if (eod_s1) begin
						pre_v           = 1'b1;
						pre_r.lex_error = 1'b1;
					end
				end else begin
					pre_v = 1'b1;
					if (kw_hit && !overlong_q) begin
						pre_r.token_code = kw_code;
					end else begin
						pre_r.lex_error = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (idle_go) begin
			priority if (is_space) begin
				id_v = 1'b0;
			end else if (is_lbr) begin
				id_v            = 1'b1;
				id_r.token_code = TOK_LBRACE;
			end else if (is_rbr) begin
				id_v            = 1'b1;
				id_r.token_code = TOK_RBRACE;
			end else if (is_digit) begin
				id_v              = eod_s1;
				id_r.token_code   = TOK_NUMBER;
				id_r.number_value = digit_val;
			end else if (is_letter) begin
				id_v           = eod_s1;
				id_r.lex_error = 1'b1;
			end else begin
				id_v           = 1'b1;
				id_r.lex_error = 1'b1;
			end
		end
	end

	always_comb begin
		push.v0             = advance && (pre_v || id_v);
		push.v1             = advance && pre_v && id_v;
		push.r0             = pre_v ? pre_r : id_r;
		push.r0.last_of_run = !(pre_v && id_v);
		push.r1             = id_r;
		push.r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			acc_q      <= '0;
			len_q      <= '0;
			overlong_q <= 1'b0;
		end else if (advance) begin
			mode_q     <= mode_d;
			acc_q      <= acc_d;
			len_q      <= len_d;
			overlong_q <= overlong_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ch_we) begin
			chars_q[ch_idx] <= byte_s1;
		end
	end

`ifndef NO_ASSERTIONS
	a_two_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && !push.r0.last_of_run)
		else $error("second result without a leading first result");
	a_eod_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eod_s1) |=> mode_q == MODE_IDLE)
		else $error("lexer not idle after end of data");
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.r0.lex_error) |->
		(push.r0.token_code == TOK_LBRACE && push.r0.number_value == '0))
		else $error("error result carries token data");
`endif

endmodule

// ===== rtl/core/kwnb_rq.sv =====
module kwnb_rq (
	input  logic                clk,
	input  logic                arst_n,
	input  kwnb_pkg::lex_push_t push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output kwnb_pkg::lex_res_t  out_res
);
	import kwnb_pkg::*;

	localparam int PW = $clog2(RQ_DEPTH);
	localparam int CW = $clog2(RQ_DEPTH + 1);

	lex_res_t      mem_q [RQ_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [CW-1:0] n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rd_q];
	assign room      = cnt_q <= CW'(RQ_DEPTH - 2);
	assign n_push    = CW'(push.v0) + CW'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_q + PW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[PW-1:0];
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + n_push - CW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> cnt_q <= CW'(RQ_DEPTH - 2))
		else $error("push into result queue without room");
	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 && !push.v0) |=> cnt_q == '0)
		else $error("result queue count moved without a push");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(RQ_DEPTH))
		else $error("result queue count above depth");
`endif

endmodule

// ===== rtl/core/keyword_number_brace_lexer.sv =====
// Streaming lexer: one text byte per s-side transaction, one token per m-side
// transaction. Bytes are taken at one per cycle while the result queue has room; the
// byte sits in an input register, is classified and matched against the keyword table
// in that cycle, and its results land in a four-entry result queue, so a token passes
// the input register and the queue. A byte that both closes a token and is a brace, an
// error or a one-digit number at end of data yields two results, which drain at one
// per cycle while m_tready is high; the queue stalls the s side only when m_tready
// holds it back. tlast on the m side marks the last result caused by one byte.
module keyword_number_brace_lexer #(
	parameter int MAX_KEYWORD_LEN = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // byte_in
	input  logic        s_tlast,  // end_of_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // token_code[4:0], number_value[35:5], lex_error[36]
	output logic        m_tlast   // last_of_run
);
	import kwnb_pkg::*;

	lex_push_t push;
	logic      room;
	lex_res_t  res;

	kwnb_lex #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_lex (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.byte_in     (s_tdata),
		.end_of_data (s_tlast),
		.room        (room),
		.push        (push)
	);

	kwnb_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {3'b0, res.lex_error, res.number_value, res.token_code};
	assign m_tlast = res.last_of_run;

endmodule
